FILE: hdl/cfs_pkg.sv
// shared types and constants for the circular fifo with search
package cfs_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CAP_W   = 5;

    // capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes; the unused code behaves as a find
    localparam logic [1:0] KIND_ENQ  = 2'd0;
    localparam logic [1:0] KIND_DEQ  = 2'd1;
    localparam logic [1:0] KIND_FIND = 2'd2;

    typedef enum logic [2:0] {
        STAT_ENQUEUED   = 3'd0,
        STAT_OVERFLOW   = 3'd1,
        STAT_DEQUEUED   = 3'd2,
        STAT_UNDERFLOW  = 3'd3,
        STAT_FOUND      = 3'd4,
        STAT_NOT_FOUND  = 3'd5,
        STAT_FIND_EMPTY = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] result_value;
    } t_result;

endpackage

FILE: hdl/cfs_ctrl.sv
// sequencer: pointers, occupancy, memory requests and the shared search comparator
module cfs_ctrl
    import cfs_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int unsigned OW    = $clog2(DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  t_cmd                      i_cmd,
    input  logic [OW-1:0]             i_eff_cap,
    output logic                      o_busy,
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output logic signed [VALUE_W-1:0] o_wdata,
    output logic [AW-1:0]             o_raddr,
    input  logic signed [VALUE_W-1:0] i_rd_data,
    output logic                      o_done,
    output t_result                   o_result
);

    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

    t_state                    r_state, n_state;
    logic [AW-1:0]             r_head, n_head;
    logic [AW-1:0]             r_tail, n_tail;
    logic [AW-1:0]             r_scan_ptr, n_scan_ptr;
    logic [OW-1:0]             r_occ, n_occ;
    logic [OW-1:0]             r_scan_cnt, n_scan_cnt;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic                      r_done, n_done;
    t_result                   r_result, n_result;
    logic [OW-1:0]             scan_cnt_inc;

    function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
        return (p == LAST_POS) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_ptr <= n_scan_ptr;
        r_scan_cnt <= n_scan_cnt;
        r_value    <= n_value;
        r_result   <= n_result;
    end

    assign scan_cnt_inc = r_scan_cnt + OW'(1);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_occ      = r_occ;
        n_scan_ptr = r_scan_ptr;
        n_scan_cnt = r_scan_cnt;
        n_value    = r_value;
        n_done     = 1'b0;
        n_result   = r_result;
        o_we       = 1'b0;
        o_waddr    = r_tail;
        o_wdata    = i_cmd.value;
        o_raddr    = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_value = i_cmd.value;
                    n_result.result_value = i_cmd.value;
                    case (i_cmd.kind)
                        KIND_ENQ: begin
                            n_done = 1'b1;
                            if (r_occ >= i_eff_cap) begin
                                n_result.status = STAT_OVERFLOW;
                            end else begin
                                o_we            = 1'b1;
                                n_tail          = next_pos(r_tail);
                                n_occ           = r_occ + OW'(1);
                                n_result.status = STAT_ENQUEUED;
                            end
                        end
                        KIND_DEQ: begin
                            if (r_occ == '0) begin
                                n_done          = 1'b1;
                                n_result.status = STAT_UNDERFLOW;
                            end else begin
                                n_state = S_DEQ;
                            end
                        end
                        default: begin
                            if (r_occ == '0) begin
                                n_done          = 1'b1;
                                n_result.status = STAT_FIND_EMPTY;
                            end else begin
                                // head read issued now, compared next cycle
                                n_scan_ptr = next_pos(r_head);
                                n_scan_cnt = '0;
                                n_state    = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_DEQ: begin
                n_done                = 1'b1;
                n_result.status       = STAT_DEQUEUED;
                n_result.result_value = i_rd_data;
                n_head                = next_pos(r_head);
                n_occ                 = r_occ - OW'(1);
                n_state               = S_IDLE;
            end
            S_SCAN: begin
                // compare one entry while fetching the following one
                o_raddr    = r_scan_ptr;
                n_scan_ptr = next_pos(r_scan_ptr);
                n_scan_cnt = scan_cnt_inc;
                if (i_rd_data == r_value) begin
                    n_done          = 1'b1;
                    n_result.status = STAT_FOUND;
                    n_state         = S_IDLE;
                end else if (scan_cnt_inc == r_occ) begin
                    n_done          = 1'b1;
                    n_result.status = STAT_NOT_FOUND;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: hdl/circular_fifo_with_search_unit.sv
// top level of the circular fifo with search: capacity register, entry store, sequencer
//
// usage
// - command channel: drive i_cmd and raise start; the transaction is taken at a
//   rising edge where start is high and busy is low. kind 0 enqueues, 1 dequeues,
//   2 (and 3) searches for i_cmd.value from oldest to newest entry
// - result channel: o_valid is high for exactly one cycle with o_result; the
//   receiver cannot stall, so each result must be captured in that cycle
// - configuration: i_cfg_we with i_cfg_data writes the capacity; write only while
//   the block is idle. 0 or a value above DEPTH means DEPTH
// - sequencing: enqueue, overflow, underflow and find on empty give a registered result
//   and busy stays low, so one such command can follow every cycle. a dequeue holds
//   busy high in the S_DEQ state for one registered memory read. a find holds busy
//   high in the S_SCAN state, where the single comparator checks one stored entry
//   per cycle against the key until it finds a match or has checked every stored entry
// - a new command can be accepted in the cycle its predecessor's result is shown
// - reset (i_rst_n low, synchronous) empties the queue and sets capacity to 16;
//   there is no clearing pass, entries are only read once written
module circular_fifo_with_search_unit
    import cfs_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_cmd               i_cmd,
    input  logic               i_cfg_we,
    input  logic [CAP_W-1:0]   i_cfg_data,
    output logic               o_valid,
    output t_result            o_result
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned OW = $clog2(DEPTH + 1);

    // capacity register
    logic [CAP_W-1:0] r_capacity;
    logic [OW-1:0]    eff_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    // zero or oversized capacity falls back to the full store
    assign eff_cap = ((r_capacity == '0) || (32'(r_capacity) > DEPTH))
                     ? OW'(DEPTH) : OW'(r_capacity);

    // entry store: one write port, one registered read port
    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rd_data;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [AW-1:0]             mem_raddr;
    logic signed [VALUE_W-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // sequencer with the shared search comparator
    cfs_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .OW    (OW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_cmd     (i_cmd),
        .i_eff_cap (eff_cap),
        .o_busy    (busy),
        .o_we      (mem_we),
        .o_waddr   (mem_waddr),
        .o_wdata   (mem_wdata),
        .o_raddr   (mem_raddr),
        .i_rd_data (r_rd_data),
        .o_done    (o_valid),
        .o_result  (o_result)
    );

endmodule
